### hdl/gdfb_pkg.sv
// ----------------------------------------------------------------------------
// gdfb_pkg
// Shared types and constants of the Gaussian-derivative filter bank.
// ----------------------------------------------------------------------------
package gdfb_pkg;

  // fixed field widths
  localparam int TC_BITS        = 6;
  localparam int TAP_INDEX_BITS = 5;
  localparam int OUT_BITS       = 39;

  localparam logic [TC_BITS-1:0] TAP_COUNT_RESET = 6'd32;

  // item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // number of kernels in the bank
  localparam int NUM_KERNELS = 3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic ready;
    logic capture;
    logic full;
  } ctrl_t;

endpackage

### hdl/gdfb_if.sv
// ----------------------------------------------------------------------------
// gdfb_if
// Valid/ready channels of the filter bank: input items and result items.
// ----------------------------------------------------------------------------
interface gdfb_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
);
  logic                                       valid;
  logic                                       ready;
  logic                                       op;
  logic signed [SAMPLE_BITS-1:0]              sample;
  logic                                       last_sample;
  logic        [gdfb_pkg::TAP_INDEX_BITS-1:0] tap_index;
  logic signed [COEF_BITS-1:0]                coef_smooth;
  logic signed [COEF_BITS-1:0]                coef_first;
  logic signed [COEF_BITS-1:0]                coef_second;

  modport source (
    output valid, op, sample, last_sample, tap_index,
           coef_smooth, coef_first, coef_second,
    input  ready
  );
  modport sink (
    input  valid, op, sample, last_sample, tap_index,
           coef_smooth, coef_first, coef_second,
    output ready
  );
endinterface

interface gdfb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 window_full;
  logic signed [gdfb_pkg::OUT_BITS-1:0] smooth_out;
  logic signed [gdfb_pkg::OUT_BITS-1:0] first_deriv_out;
  logic signed [gdfb_pkg::OUT_BITS-1:0] second_deriv_out;

  modport source (
    output valid, window_full, smooth_out, first_deriv_out, second_deriv_out,
    input  ready
  );
  modport sink (
    input  valid, window_full, smooth_out, first_deriv_out, second_deriv_out,
    output ready
  );
endinterface

### hdl/gdfb_cell.sv
// ----------------------------------------------------------------------------
// gdfb_cell
// One tap of the filter chain: history sample, three coefficients, three
// registered products and three partial sums handed on to the next tap.
// ----------------------------------------------------------------------------
module gdfb_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18,
  parameter int ACC_BITS    = 39
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_en_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  input  logic                          load_en_i,
  input  logic signed [COEF_BITS-1:0]   coef_i [gdfb_pkg::NUM_KERNELS],
  input  logic                          tap_en_i,
  input  logic signed [ACC_BITS-1:0]    sum_i  [gdfb_pkg::NUM_KERNELS],
  output logic signed [ACC_BITS-1:0]    sum_o  [gdfb_pkg::NUM_KERNELS]
);
  import gdfb_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [COEF_BITS-1:0]   coef_q [NUM_KERNELS];
  logic signed [PROD_BITS-1:0]   prod_d [NUM_KERNELS];
  logic signed [PROD_BITS-1:0]   prod_q [NUM_KERNELS];
  logic signed [ACC_BITS-1:0]    sum_d  [NUM_KERNELS];
  logic signed [ACC_BITS-1:0]    sum_q  [NUM_KERNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_en_i) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      coef_q <= coef_i;
    end
  end

  // taps beyond the active kernel length contribute nothing
  always_comb begin
    for (int k = 0; k < NUM_KERNELS; k++) begin
      if (tap_en_i) begin
        prod_d[k] = PROD_BITS'(sample_q) * PROD_BITS'(coef_q[k]);
      end else begin
        prod_d[k] = '0;
      end
      sum_d[k] = sum_i[k] + ACC_BITS'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign sample_o = sample_q;
  assign sum_o    = sum_q;

endmodule

### hdl/gdfb_ctrl.sv
// ----------------------------------------------------------------------------
// gdfb_ctrl
// Sequencer of the filter bank: fill count, tap mask and the wait for the
// partial sums to run down the cell chain.
// ----------------------------------------------------------------------------
module gdfb_ctrl #(
  parameter int TAPS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_acc_i,
  input  logic                         last_sample_i,
  input  logic [gdfb_pkg::TC_BITS-1:0] tap_count_i,
  input  logic                         out_free_i,
  output logic [TAPS-1:0]              tap_en_o,
  output gdfb_pkg::ctrl_t              ctrl_o
);
  import gdfb_pkg::*;

  localparam int FILL_BITS = $clog2(TAPS + 1);
  localparam int CMP_BITS  = (FILL_BITS > TC_BITS) ? FILL_BITS : TC_BITS;
  localparam int CNT_BITS  = $clog2(TAPS + 2);
  localparam logic [CNT_BITS-1:0]  LAST_CNT = CNT_BITS'(TAPS + 1);
  localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(TAPS);
  localparam logic [CMP_BITS-1:0]  TAPS_CMP = CMP_BITS'(TAPS);

  state_e               state_q, state_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [FILL_BITS-1:0] fill_q, fill_d, fill_inc;
  logic                 full_q, full_d;
  logic [CMP_BITS-1:0]  tc_ext, k_len;

  // kernel length clamped to 1..TAPS
  always_comb begin
    tc_ext = CMP_BITS'(tap_count_i);
    if (tc_ext == '0) begin
      k_len = CMP_BITS'(1);
    end else if (tc_ext > TAPS_CMP) begin
      k_len = TAPS_CMP;
    end else begin
      k_len = tc_ext;
    end
  end

  for (genvar j = 0; j < TAPS; j++) begin : g_mask
    assign tap_en_o[j] = CMP_BITS'(j) < k_len;
  end

  assign fill_inc = (fill_q < FILL_MAX) ? fill_q + FILL_BITS'(1) : fill_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    full_d  = full_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.ready = 1'b1;
        if (sample_acc_i) begin
          state_d = ST_RUN;
          cnt_d   = '0;
          full_d  = CMP_BITS'(fill_inc) >= k_len;
          fill_d  = last_sample_i ? '0 : fill_inc;
        end
      end
      ST_RUN: begin
        // last partial sum leaves the chain when the count tops out
        if (cnt_q != LAST_CNT) begin
          cnt_d = cnt_q + CNT_BITS'(1);
        end else if (out_free_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    ctrl_o.full = full_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      fill_q  <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      full_q  <= full_d;
    end
  end

endmodule

### hdl/gaussian_derivative_filter_bank.sv
// ----------------------------------------------------------------------------
// gaussian_derivative_filter_bank
// Three-kernel FIR bank (smoothing, first and second derivative) built as a
// chain of tap cells with coefficients loaded per tap.
// ----------------------------------------------------------------------------
// sequencing: a sample item is taken only while idle; no new item is taken until
//   its partial sums have run down the tap chain one cell per cycle and the result
//   is captured once the output register is free; load items do not leave idle
// reset: history and fill count cleared, tap_count set to 32,
//   coefficients undefined until loaded
// ----------------------------------------------------------------------------
module gaussian_derivative_filter_bank #(
  parameter int TAPS        = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gdfb_pkg::TC_BITS-1:0] cfg_wdata_i,
  gdfb_in_if.sink                      in_i,
  gdfb_out_if.source                   out_o
);
  import gdfb_pkg::*;

  localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + $clog2(TAPS);
  localparam int SAT_BITS = (ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS;
  localparam logic signed [SAT_BITS-1:0] OUT_MAX =
    SAT_BITS'((64'(1) << (OUT_BITS - 1)) - 64'(1));
  localparam logic signed [SAT_BITS-1:0] OUT_MIN = -OUT_MAX - SAT_BITS'(1);

  logic [TC_BITS-1:0] tap_count_q;
  logic               accept, sample_acc, load_acc, out_free;
  logic [TAPS-1:0]    tap_en;
  ctrl_t              ctrl;

  logic signed [SAMPLE_BITS-1:0] hist   [TAPS];
  logic signed [ACC_BITS-1:0]    sums   [TAPS][NUM_KERNELS];
  logic signed [ACC_BITS-1:0]    sum_zero [NUM_KERNELS];
  logic signed [COEF_BITS-1:0]   coef_in  [NUM_KERNELS];

  logic                          out_valid_q;
  logic                          full_out_q;
  logic signed [OUT_BITS-1:0]    res_q [NUM_KERNELS];
  logic signed [OUT_BITS-1:0]    res_d [NUM_KERNELS];
  logic signed [SAT_BITS-1:0]    sum_w [NUM_KERNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RESET;
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = ctrl.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign sample_acc = accept && (in_i.op == OP_SAMPLE);
  assign load_acc   = accept && (in_i.op == OP_LOAD);
  assign out_free   = !out_valid_q || out_o.ready;

  assign sum_zero   = '{default: '0};
  assign coef_in[0] = in_i.coef_smooth;
  assign coef_in[1] = in_i.coef_first;
  assign coef_in[2] = in_i.coef_second;

  gdfb_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_acc_i  (sample_acc),
    .last_sample_i (in_i.last_sample),
    .tap_count_i   (tap_count_q),
    .out_free_i    (out_free),
    .tap_en_o      (tap_en),
    .ctrl_o        (ctrl)
  );

  for (genvar j = 0; j < TAPS; j++) begin : g_tap
    logic load_en;
    assign load_en = load_acc && (int'(in_i.tap_index) == j);

    if (j == 0) begin : g_head
      gdfb_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_BITS    (ACC_BITS)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_en_i (sample_acc),
        .sample_i   (in_i.sample),
        .sample_o   (hist[j]),
        .load_en_i  (load_en),
        .coef_i     (coef_in),
        .tap_en_i   (tap_en[j]),
        .sum_i      (sum_zero),
        .sum_o      (sums[j])
      );
    end else begin : g_body
      gdfb_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_BITS    (ACC_BITS)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_en_i (sample_acc),
        .sample_i   (hist[j-1]),
        .sample_o   (hist[j]),
        .load_en_i  (load_en),
        .coef_i     (coef_in),
        .tap_en_i   (tap_en[j]),
        .sum_i      (sums[j-1]),
        .sum_o      (sums[j])
      );
    end
  end

  // saturate the chain output to the result width, zero until window full
  always_comb begin
    for (int k = 0; k < NUM_KERNELS; k++) begin
      sum_w[k] = SAT_BITS'(sums[TAPS-1][k]);
      if (!ctrl.full) begin
        res_d[k] = '0;
      end else if (sum_w[k] > OUT_MAX) begin
        res_d[k] = OUT_MAX[OUT_BITS-1:0];
      end else if (sum_w[k] < OUT_MIN) begin
        res_d[k] = OUT_MIN[OUT_BITS-1:0];
      end else begin
        res_d[k] = sum_w[k][OUT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.capture) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.capture) begin
      full_out_q <= ctrl.full;
      res_q      <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.window_full      = full_out_q;
  assign out_o.smooth_out       = res_q[0];
  assign out_o.first_deriv_out  = res_q[1];
  assign out_o.second_deriv_out = res_q[2];

endmodule

### verif/gaussian_derivative_filter_bank_test.sv
// ----------------------------------------------------------------------------
// gaussian_derivative_filter_bank_test
// Self-checking bench for the three-kernel FIR bank. Coefficient loads and
// sample items go in through the valid/ready input channel, and the result
// channel is checked field by field against a cycle-free model of the bank.
// Directed items cover sample and coefficient extremes, signal ends and the
// tap count limits, then random signals run under several tap count
// settings. Both sides of the handshake idle at random outside the quiet phases.
// ----------------------------------------------------------------------------
module gaussian_derivative_filter_bank_test;
  import gdfb_pkg::*;

  localparam int TAPS        = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;
  localparam int HOLD_OFF    = TAPS + 3;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
    logic [TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [COEF_BITS-1:0]   coef_smooth;
    logic signed [COEF_BITS-1:0]   coef_first;
    logic signed [COEF_BITS-1:0]   coef_second;
  } filt_item_t;

  typedef struct {
    logic                       full;
    logic signed [OUT_BITS-1:0] smooth;
    logic signed [OUT_BITS-1:0] first;
    logic signed [OUT_BITS-1:0] second;
  } bank_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [TC_BITS-1:0] cfg_wdata_i;

  gdfb_in_if #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) in_if ();
  gdfb_out_if out_if ();

  gaussian_derivative_filter_bank #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #2 clk_i = ~clk_i;

  // model state of the bank
  logic signed [SAMPLE_BITS-1:0] hist_line   [TAPS];
  logic signed [COEF_BITS-1:0]   kern_smooth [TAPS];
  logic signed [COEF_BITS-1:0]   kern_first  [TAPS];
  logic signed [COEF_BITS-1:0]   kern_second [TAPS];
  int                            seen_count;
  logic [TC_BITS-1:0]            tap_setting;

  filt_item_t   feed_items[$];
  bank_result_t expected_sums[$];
  filt_item_t   cur_item;

  int mismatches  = 0;
  int send_gap    = 0;
  int stall_left  = 0;
  int idle_cycles = 0;
  bit quiet       = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("error: %s", msg);
    mismatches++;
  endtask

  // most gaps short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_taps(input logic [TC_BITS-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > TAPS) return TAPS;
    return int'(v);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] clamp_out(input longint s);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    lo = -hi - 1;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s[OUT_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2: return '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_BITS-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(COEF_BITS-1){1'b1}}};
      1: return {1'b1, {(COEF_BITS-1){1'b0}}};
      2: return '0;
      default: return COEF_BITS'($urandom);
    endcase
  endfunction

  // one accepted item through the bank, expected sums queued for samples
  task automatic filter_bank_step(input filt_item_t it);
    bank_result_t r;
    int           k;
    longint       a0, a1, a2;
    if (it.op == OP_LOAD) begin
      if (int'(it.tap_index) < TAPS) begin
        kern_smooth[it.tap_index] = it.coef_smooth;
        kern_first[it.tap_index]  = it.coef_first;
        kern_second[it.tap_index] = it.coef_second;
      end
      return;
    end
    k = eff_taps(tap_setting);
    for (int j = TAPS - 1; j > 0; j--) hist_line[j] = hist_line[j-1];
    hist_line[0] = it.sample;
    if (seen_count < TAPS) seen_count++;
    r.full = (seen_count >= k);
    a0 = 0;
    a1 = 0;
    a2 = 0;
    if (r.full) begin
      for (int j = 0; j < k; j++) begin
        a0 += longint'(hist_line[j]) * longint'(kern_smooth[j]);
        a1 += longint'(hist_line[j]) * longint'(kern_first[j]);
        a2 += longint'(hist_line[j]) * longint'(kern_second[j]);
      end
    end
    r.smooth = clamp_out(a0);
    r.first  = clamp_out(a1);
    r.second = clamp_out(a2);
    expected_sums.push_back(r);
    if (it.last_sample) seen_count = 0;
  endtask

  task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
    filt_item_t it;
    it.op          = OP_SAMPLE;
    it.sample      = s;
    it.last_sample = last;
    it.tap_index   = TAP_INDEX_BITS'($urandom);
    it.coef_smooth = COEF_BITS'($urandom);
    it.coef_first  = COEF_BITS'($urandom);
    it.coef_second = COEF_BITS'($urandom);
    feed_items.push_back(it);
  endtask

  task automatic queue_load(input logic [TAP_INDEX_BITS-1:0] tap,
                            input logic signed [COEF_BITS-1:0] cs,
                            input logic signed [COEF_BITS-1:0] cf,
                            input logic signed [COEF_BITS-1:0] c2);
    filt_item_t it;
    it.op          = OP_LOAD;
    it.sample      = SAMPLE_BITS'($urandom);
    it.last_sample = 1'($urandom);
    it.tap_index   = tap;
    it.coef_smooth = cs;
    it.coef_first  = cf;
    it.coef_second = c2;
    feed_items.push_back(it);
  endtask

  // wait until everything sent has come back, then let the tap chain settle
  task automatic drain();
    do @(negedge clk_i);
    while (feed_items.size() != 0 || in_if.valid || expected_sums.size() != 0);
    repeat (HOLD_OFF) @(negedge clk_i);
  endtask

  task automatic write_tap_count(input logic [TC_BITS-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tap_setting = v;
    @(negedge clk_i);
  endtask

  // whole signals mostly, some short or unterminated, some loose noise items
  task automatic build_phase(input int n_items, input int k);
    int made;
    int len;
    bit ends;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0)
          queue_sample(rand_sample(), 1'($urandom_range(0, 1)));
        else
          queue_load(TAP_INDEX_BITS'($urandom), rand_coef(), rand_coef(), rand_coef());
        made++;
      end else begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, k);
        else len = $urandom_range(k, k + 24);
        ends = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            queue_load(TAP_INDEX_BITS'($urandom), rand_coef(), rand_coef(), rand_coef());
            made++;
          end
          queue_sample(rand_sample(), ends && (i == len - 1));
          made++;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    filt_item_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) filter_bank_step(cur_item);
      if (in_if.valid && !in_if.ready) begin
        // hold the item until the bank takes it
      end else if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (feed_items.size() > 0) begin
        nxt = feed_items.pop_front();
        in_if.op          <= nxt.op;
        in_if.sample      <= nxt.sample;
        in_if.last_sample <= nxt.last_sample;
        in_if.tap_index   <= nxt.tap_index;
        in_if.coef_smooth <= nxt.coef_smooth;
        in_if.coef_first  <= nxt.coef_first;
        in_if.coef_second <= nxt.coef_second;
        in_if.valid       <= 1'b1;
        cur_item = nxt;
        send_gap = quiet ? 0 : gap_len();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    bank_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("result item with no sample item pending");
        end else begin
          want = expected_sums.pop_front();
          if (out_if.window_full !== want.full)
            report_mismatch($sformatf("window_full got %b want %b",
                                      out_if.window_full, want.full));
          if (out_if.smooth_out !== want.smooth)
            report_mismatch($sformatf("smooth_out got %0d want %0d",
                                      out_if.smooth_out, want.smooth));
          if (out_if.first_deriv_out !== want.first)
            report_mismatch($sformatf("first_deriv_out got %0d want %0d",
                                      out_if.first_deriv_out, want.first));
          if (out_if.second_deriv_out !== want.second)
            report_mismatch($sformatf("second_deriv_out got %0d want %0d",
                                      out_if.second_deriv_out, want.second));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = gap_len();
        if (stall_left > 0) begin
          stall_left--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [TC_BITS-1:0] phase_taps [12];
    logic signed [COEF_BITS-1:0] cmax, cmin;
    logic signed [SAMPLE_BITS-1:0] smax, smin;
    phase_taps = '{6'd63, 6'd1, 6'd32, 6'd5, 6'd0, 6'd33,
                   6'd31, 6'd2, 6'd17, 6'd32, 6'd3, 6'd9};
    cmax = {1'b0, {(COEF_BITS-1){1'b1}}};
    cmin = {1'b1, {(COEF_BITS-1){1'b0}}};
    smax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    smin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.op = OP_SAMPLE;
    in_if.sample = '0;
    in_if.last_sample = 1'b0;
    in_if.tap_index = '0;
    in_if.coef_smooth = '0;
    in_if.coef_first = '0;
    in_if.coef_second = '0;
    out_if.ready = 1'b0;
    for (int j = 0; j < TAPS; j++) begin
      hist_line[j]   = '0;
      kern_smooth[j] = '0;
      kern_first[j]  = '0;
      kern_second[j] = '0;
    end
    seen_count  = 0;
    tap_setting = TAP_COUNT_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every tap gets coefficients before any window can fill
    queue_load(TAP_INDEX_BITS'(0), cmax, cmin, cmax);
    queue_load(TAP_INDEX_BITS'(1), cmin, cmax, cmin);
    for (int j = 2; j < TAPS; j++)
      queue_load(TAP_INDEX_BITS'(j), rand_coef(), rand_coef(), rand_coef());
    // reset tap count: window does not fill
    queue_sample(smax, 1'b0);
    queue_sample(smin, 1'b0);
    queue_sample(16'sd1, 1'b0);
    drain();

    // two taps: extremes, signal end, coefficient load mid-signal
    write_tap_count(6'd2);
    queue_sample(smax, 1'b0);
    queue_sample(smax, 1'b0);
    queue_sample(smin, 1'b0);
    queue_sample(smin, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample(-16'sd1, 1'b1);
    queue_sample(16'sd5, 1'b0);
    queue_load(TAP_INDEX_BITS'(1), cmax, cmax, cmin);
    queue_sample(16'sd7, 1'b0);
    queue_sample(smax, 1'b1);
    drain();

    // zero acts as one tap
    write_tap_count(6'd0);
    queue_sample(smin, 1'b1);
    queue_sample(smax, 1'b0);
    queue_sample(16'sd1, 1'b1);
    drain();

    for (int p = 0; p < 12; p++) begin
      quiet = (p % 4 == 2);
      write_tap_count(phase_taps[p]);
      build_phase(103, eff_taps(phase_taps[p]));
      drain();
    end
    quiet = 1'b0;

    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
